/* src/bsr_pkg.sv */
// Shared types and constants for the battery status register block.
package bsr_pkg;

    typedef enum logic [1:0] {
        KIND_BUS_RD   = 2'd0,
        KIND_BUS_WR   = 2'd1,
        KIND_HOST_SET = 2'd2,
        KIND_HOST_RD  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [11:0] offset;
        logic [31:0] data;
        logic        ac_side;
        logic [3:0]  prop_code;
    } t_item;

    // Property codes
    localparam logic [3:0] PROP_ONLINE       = 4'd0;
    localparam logic [3:0] PROP_STATUS       = 4'd1;
    localparam logic [3:0] PROP_HEALTH       = 4'd2;
    localparam logic [3:0] PROP_HAS_BATTERY  = 4'd3;
    localparam logic [3:0] PROP_PRESENT      = 4'd4;
    localparam logic [3:0] PROP_CAPACITY     = 4'd5;
    localparam logic [3:0] PROP_VOLTAGE      = 4'd6;
    localparam logic [3:0] PROP_TEMP         = 4'd7;
    localparam logic [3:0] PROP_CHARGE_CNT   = 4'd8;
    localparam logic [3:0] PROP_VOLTAGE_MAX  = 4'd9;
    localparam logic [3:0] PROP_CURRENT_MAX  = 4'd10;
    localparam logic [3:0] PROP_CURRENT_NOW  = 4'd11;
    localparam logic [3:0] PROP_CURRENT_AVG  = 4'd12;
    localparam logic [3:0] PROP_CHARGE_FULL  = 4'd13;
    localparam logic [3:0] PROP_CYCLE_COUNT  = 4'd14;
    localparam logic [3:0] PROP_NONE         = 4'd15;

    // Bus register map (byte offsets)
    localparam logic [11:0] OFF_STATUS       = 12'h000;
    localparam logic [11:0] OFF_ENABLE       = 12'h004;
    localparam logic [11:0] OFF_ONLINE       = 12'h008;
    localparam logic [11:0] OFF_CHG_STATUS   = 12'h00C;
    localparam logic [11:0] OFF_HEALTH       = 12'h010;
    localparam logic [11:0] OFF_PRESENT      = 12'h014;
    localparam logic [11:0] OFF_CAPACITY     = 12'h018;
    localparam logic [11:0] OFF_VOLTAGE      = 12'h01C;
    localparam logic [11:0] OFF_TEMP         = 12'h020;
    localparam logic [11:0] OFF_CHARGE_CNT   = 12'h024;
    localparam logic [11:0] OFF_VOLTAGE_MAX  = 12'h028;
    localparam logic [11:0] OFF_CURRENT_MAX  = 12'h02C;
    localparam logic [11:0] OFF_CURRENT_NOW  = 12'h030;
    localparam logic [11:0] OFF_CURRENT_AVG  = 12'h034;
    localparam logic [11:0] OFF_CHARGE_FULL  = 12'h038;
    localparam logic [11:0] OFF_CYCLE_COUNT  = 12'h040;

    // Interrupt status bits
    localparam logic [1:0] CHANGED_BATT = 2'b01;
    localparam logic [1:0] CHANGED_AC   = 2'b10;

    // Fixed and reset values
    localparam logic [31:0] VOLTAGE_UV_VAL     = 32'd5000000;
    localparam logic [31:0] TEMP_DECI_C_VAL    = 32'd250;
    localparam logic [31:0] VOLTAGE_LIMIT_VAL  = 32'd5000000;
    localparam logic [31:0] CURRENT_LIMIT_VAL  = 32'd5000000;
    localparam logic [31:0] CURRENT_RST_VAL    = 32'd900000;
    localparam logic [31:0] FULL_CHARGE_RST    = 32'd3000000;
    localparam logic [31:0] CYCLES_RST_VAL     = 32'd10;
    localparam logic [31:0] CAPACITY_RST_VAL   = 32'd100;
    localparam logic [31:0] CHARGE_CNT_VAL     = 32'd10000;

endpackage

/* src/battery_status_register_block_unit.sv */
// Top level of the battery status register block: stream ports and result register.
// An accepted input transfer is held in the input register, then its result in the result register.
// Throughput: one item per cycle; the input register and the result register
// both advance whenever the result register is empty or being taken.
// Reset (i_rst_n low, synchronous) empties both stages and loads the
// property registers with their power-on values; interrupt status and enable clear.
module battery_status_register_block_unit #(
    parameter bit HAS_BATTERY = 1'b1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [11:0] offset, [43:12] data, [44] ac_side, [48:45] prop_code, [55:49] zero
    input  logic [55:0] s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] read_data, [32] irq, [39:33] zero
    output logic [39:0] m_axis_tdata
);

    bsr_pkg::t_item in_item;
    bsr_pkg::t_item cur_item;
    logic           cur_valid;
    logic           out_free;
    logic           fire;
    logic [31:0]    read_data;
    logic           irq;

    logic           r_out_valid;
    logic [31:0]    r_read_data;
    logic           r_irq;

    assign in_item.kind      = bsr_pkg::t_kind'(s_axis_tuser);
    assign in_item.offset    = s_axis_tdata[11:0];
    assign in_item.data      = s_axis_tdata[43:12];
    assign in_item.ac_side   = s_axis_tdata[44];
    assign in_item.prop_code = s_axis_tdata[48:45];

    assign out_free = !r_out_valid || m_axis_tready;
    assign fire     = cur_valid && out_free;

    bsr_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_item    (in_item),
        .i_advance (out_free),
        .o_ready   (s_axis_tready),
        .o_valid   (cur_valid),
        .o_item    (cur_item)
    );

    bsr_core #(
        .HAS_BATTERY (HAS_BATTERY)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (cur_item),
        .o_read_data (read_data),
        .o_irq       (irq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= cur_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_read_data <= read_data;
            r_irq       <= irq;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_irq, r_read_data};

endmodule

/* src/bsr_in_reg.sv */
// Input register stage: captures one request item per transfer.
module bsr_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  bsr_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_ready,
    output logic           o_valid,
    output bsr_pkg::t_item o_item
);

    logic           r_valid;
    bsr_pkg::t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

/* src/bsr_core.sv */
// Property and interrupt registers with the access decode for one item.
module bsr_core #(
    parameter bit HAS_BATTERY = 1'b1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  bsr_pkg::t_item i_item,
    output logic [31:0]    o_read_data,
    output logic           o_irq
);

    localparam logic [31:0] BATT_ONE     = HAS_BATTERY ? 32'd1 : 32'd0;
    localparam logic [31:0] CAPACITY_RST = HAS_BATTERY ? bsr_pkg::CAPACITY_RST_VAL : 32'd0;
    localparam logic [31:0] CHARGE_CNT   = HAS_BATTERY ? bsr_pkg::CHARGE_CNT_VAL : 32'd0;

    logic [1:0]  r_pending, n_pending;
    logic [31:0] r_mask, n_mask;
    logic [31:0] r_online, n_online;
    logic [31:0] r_charge, n_charge;
    logic [31:0] r_health, n_health;
    logic [31:0] r_present, n_present;
    logic [31:0] r_capacity, n_capacity;
    logic [31:0] r_cur_now, n_cur_now;
    logic [31:0] r_cur_avg, n_cur_avg;
    logic [31:0] r_full, n_full;
    logic [31:0] r_cycles, n_cycles;

    logic [3:0]  bus_code;
    logic [3:0]  sel_code;
    logic [31:0] prop_val;
    logic [31:0] status_val;

    // Bus offsets that alias a property
    always_comb begin
        case (i_item.offset)
            bsr_pkg::OFF_ONLINE:      bus_code = bsr_pkg::PROP_ONLINE;
            bsr_pkg::OFF_CHG_STATUS:  bus_code = bsr_pkg::PROP_STATUS;
            bsr_pkg::OFF_HEALTH:      bus_code = bsr_pkg::PROP_HEALTH;
            bsr_pkg::OFF_PRESENT:     bus_code = bsr_pkg::PROP_PRESENT;
            bsr_pkg::OFF_CAPACITY:    bus_code = bsr_pkg::PROP_CAPACITY;
            bsr_pkg::OFF_VOLTAGE:     bus_code = bsr_pkg::PROP_VOLTAGE;
            bsr_pkg::OFF_TEMP:        bus_code = bsr_pkg::PROP_TEMP;
            bsr_pkg::OFF_CHARGE_CNT:  bus_code = bsr_pkg::PROP_CHARGE_CNT;
            bsr_pkg::OFF_VOLTAGE_MAX: bus_code = bsr_pkg::PROP_VOLTAGE_MAX;
            bsr_pkg::OFF_CURRENT_MAX: bus_code = bsr_pkg::PROP_CURRENT_MAX;
            bsr_pkg::OFF_CURRENT_NOW: bus_code = bsr_pkg::PROP_CURRENT_NOW;
            bsr_pkg::OFF_CURRENT_AVG: bus_code = bsr_pkg::PROP_CURRENT_AVG;
            bsr_pkg::OFF_CHARGE_FULL: bus_code = bsr_pkg::PROP_CHARGE_FULL;
            bsr_pkg::OFF_CYCLE_COUNT: bus_code = bsr_pkg::PROP_CYCLE_COUNT;
            default:                  bus_code = bsr_pkg::PROP_NONE;
        endcase
    end

    assign sel_code = (i_item.kind == bsr_pkg::KIND_HOST_RD) ? i_item.prop_code : bus_code;

    always_comb begin
        case (sel_code)
            bsr_pkg::PROP_ONLINE:       prop_val = r_online;
            bsr_pkg::PROP_STATUS:       prop_val = r_charge;
            bsr_pkg::PROP_HEALTH:       prop_val = r_health;
            bsr_pkg::PROP_HAS_BATTERY:  prop_val = BATT_ONE;
            bsr_pkg::PROP_PRESENT:      prop_val = r_present;
            bsr_pkg::PROP_CAPACITY:     prop_val = r_capacity;
            bsr_pkg::PROP_VOLTAGE:      prop_val = bsr_pkg::VOLTAGE_UV_VAL;
            bsr_pkg::PROP_TEMP:         prop_val = bsr_pkg::TEMP_DECI_C_VAL;
            bsr_pkg::PROP_CHARGE_CNT:   prop_val = CHARGE_CNT;
            bsr_pkg::PROP_VOLTAGE_MAX:  prop_val = bsr_pkg::VOLTAGE_LIMIT_VAL;
            bsr_pkg::PROP_CURRENT_MAX:  prop_val = bsr_pkg::CURRENT_LIMIT_VAL;
            bsr_pkg::PROP_CURRENT_NOW:  prop_val = r_cur_now;
            bsr_pkg::PROP_CURRENT_AVG:  prop_val = r_cur_avg;
            bsr_pkg::PROP_CHARGE_FULL:  prop_val = r_full;
            bsr_pkg::PROP_CYCLE_COUNT:  prop_val = r_cycles;
            default:                    prop_val = 32'd0;
        endcase
    end

    assign status_val = {30'd0, r_pending} & r_mask;

    always_comb begin
        n_pending   = r_pending;
        n_mask      = r_mask;
        n_online    = r_online;
        n_charge    = r_charge;
        n_health    = r_health;
        n_present   = r_present;
        n_capacity  = r_capacity;
        n_cur_now   = r_cur_now;
        n_cur_avg   = r_cur_avg;
        n_full      = r_full;
        n_cycles    = r_cycles;
        o_read_data = 32'd0;
        case (i_item.kind)
            bsr_pkg::KIND_BUS_RD: begin
                if (i_item.offset == bsr_pkg::OFF_STATUS) begin
                    o_read_data = status_val;
                    // clear on read only when something enabled was pending
                    if (status_val != 32'd0) begin
                        n_pending = 2'b00;
                    end
                end else if (i_item.offset == bsr_pkg::OFF_ENABLE) begin
                    o_read_data = r_mask;
                end else begin
                    o_read_data = prop_val;
                end
            end
            bsr_pkg::KIND_BUS_WR: begin
                if (i_item.offset == bsr_pkg::OFF_ENABLE) begin
                    n_mask = i_item.data;
                end
            end
            bsr_pkg::KIND_HOST_SET: begin
                if (HAS_BATTERY) begin
                    if (i_item.ac_side) begin
                        if (i_item.prop_code == bsr_pkg::PROP_ONLINE) begin
                            n_online = i_item.data;
                        end
                        n_pending = r_pending | bsr_pkg::CHANGED_AC;
                    end else begin
                        case (i_item.prop_code)
                            bsr_pkg::PROP_STATUS:      n_charge   = i_item.data;
                            bsr_pkg::PROP_HEALTH:      n_health   = i_item.data;
                            bsr_pkg::PROP_PRESENT:     n_present  = i_item.data;
                            bsr_pkg::PROP_CAPACITY:    n_capacity = i_item.data;
                            bsr_pkg::PROP_CURRENT_NOW: n_cur_now  = i_item.data;
                            bsr_pkg::PROP_CURRENT_AVG: n_cur_avg  = i_item.data;
                            bsr_pkg::PROP_CHARGE_FULL: n_full     = i_item.data;
                            bsr_pkg::PROP_CYCLE_COUNT: n_cycles   = i_item.data;
                            default: ;
                        endcase
                        n_pending = r_pending | bsr_pkg::CHANGED_BATT;
                    end
                end
            end
            bsr_pkg::KIND_HOST_RD: begin
                o_read_data = prop_val;
            end
            default: ;
        endcase
    end

    // Interrupt level after this item has taken effect
    assign o_irq = (({30'd0, n_pending} & n_mask) != 32'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= 2'b00;
            r_mask     <= 32'd0;
            r_online   <= 32'd1;
            r_charge   <= BATT_ONE;
            r_health   <= BATT_ONE;
            r_present  <= BATT_ONE;
            r_capacity <= CAPACITY_RST;
            r_cur_now  <= bsr_pkg::CURRENT_RST_VAL;
            r_cur_avg  <= bsr_pkg::CURRENT_RST_VAL;
            r_full     <= bsr_pkg::FULL_CHARGE_RST;
            r_cycles   <= bsr_pkg::CYCLES_RST_VAL;
        end else if (i_fire) begin
            r_pending  <= n_pending;
            r_mask     <= n_mask;
            r_online   <= n_online;
            r_charge   <= n_charge;
            r_health   <= n_health;
            r_present  <= n_present;
            r_capacity <= n_capacity;
            r_cur_now  <= n_cur_now;
            r_cur_avg  <= n_cur_avg;
            r_full     <= n_full;
            r_cycles   <= n_cycles;
        end
    end

endmodule

/* verif/tb_battery_status_register_block_unit.sv */
// Self-checking testbench for the battery status register block: stream driver, monitor, predictor.
`timescale 1ns / 1ps

module tb_battery_status_register_block_unit;

    localparam bit BATTERY_FITTED = 1'b1;
    localparam int RANDOM_ACCESSES = 1600;
    localparam int QUIET_TAIL = 200;       // last transfers run with no idling
    localparam int DRAIN_CYCLES = 12;
    localparam int WATCHDOG_LIMIT = 500;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
    } t_resp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [11:0] offset, [43:12] data, [44] ac_side, [48:45] prop_code, [55:49] zero
    logic [55:0] s_axis_tdata = '0;
    // [1:0] kind
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [31:0] read_data, [32] irq, [39:33] zero
    logic [39:0] m_axis_tdata;

    battery_status_register_block_unit #(
        .HAS_BATTERY(BATTERY_FITTED)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Predicted register file, indexed by property code
    logic [31:0] prop_value [16];
    logic [1:0]  irq_status;
    logic [31:0] irq_enable;

    bsr_pkg::t_item stim_q [$];
    bsr_pkg::t_item cur_access;
    t_resp pending_resp [$];
    int    mismatch_count = 0;
    int    send_gap = 0;
    int    sink_stall = 0;
    int    idle_cycles = 0;

    function automatic bsr_pkg::t_item mk_access(bsr_pkg::t_kind k, logic [11:0] off,
                                                 logic [31:0] d, logic ac, logic [3:0] pc);
        bsr_pkg::t_item it;
        it.kind = k;
        it.offset = off;
        it.data = d;
        it.ac_side = ac;
        it.prop_code = pc;
        return it;
    endfunction

    function automatic t_resp apply_access(bsr_pkg::t_item it);
        t_resp r;
        logic [3:0] code;
        r.read_data = '0;
        case (it.kind)
            bsr_pkg::KIND_BUS_RD: begin
                if (it.offset == bsr_pkg::OFF_STATUS) begin
                    r.read_data = {30'd0, irq_status} & irq_enable;
                    if (r.read_data != '0) irq_status = '0;
                end else if (it.offset == bsr_pkg::OFF_ENABLE) begin
                    r.read_data = irq_enable;
                end else begin
                    case (it.offset)
                        bsr_pkg::OFF_ONLINE:      code = bsr_pkg::PROP_ONLINE;
                        bsr_pkg::OFF_CHG_STATUS:  code = bsr_pkg::PROP_STATUS;
                        bsr_pkg::OFF_HEALTH:      code = bsr_pkg::PROP_HEALTH;
                        bsr_pkg::OFF_PRESENT:     code = bsr_pkg::PROP_PRESENT;
                        bsr_pkg::OFF_CAPACITY:    code = bsr_pkg::PROP_CAPACITY;
                        bsr_pkg::OFF_VOLTAGE:     code = bsr_pkg::PROP_VOLTAGE;
                        bsr_pkg::OFF_TEMP:        code = bsr_pkg::PROP_TEMP;
                        bsr_pkg::OFF_CHARGE_CNT:  code = bsr_pkg::PROP_CHARGE_CNT;
                        bsr_pkg::OFF_VOLTAGE_MAX: code = bsr_pkg::PROP_VOLTAGE_MAX;
                        bsr_pkg::OFF_CURRENT_MAX: code = bsr_pkg::PROP_CURRENT_MAX;
                        bsr_pkg::OFF_CURRENT_NOW: code = bsr_pkg::PROP_CURRENT_NOW;
                        bsr_pkg::OFF_CURRENT_AVG: code = bsr_pkg::PROP_CURRENT_AVG;
                        bsr_pkg::OFF_CHARGE_FULL: code = bsr_pkg::PROP_CHARGE_FULL;
                        bsr_pkg::OFF_CYCLE_COUNT: code = bsr_pkg::PROP_CYCLE_COUNT;
                        default:                  code = bsr_pkg::PROP_NONE;
                    endcase
                    r.read_data = prop_value[code];
                end
            end
            bsr_pkg::KIND_BUS_WR: begin
                if (it.offset == bsr_pkg::OFF_ENABLE) irq_enable = it.data;
            end
            bsr_pkg::KIND_HOST_SET: begin
                if (BATTERY_FITTED) begin
                    if (it.ac_side) begin
                        if (it.prop_code == bsr_pkg::PROP_ONLINE)
                            prop_value[bsr_pkg::PROP_ONLINE] = it.data;
                        irq_status = irq_status | bsr_pkg::CHANGED_AC;
                    end else begin
                        case (it.prop_code)
                            bsr_pkg::PROP_STATUS, bsr_pkg::PROP_HEALTH,
                            bsr_pkg::PROP_PRESENT, bsr_pkg::PROP_CAPACITY,
                            bsr_pkg::PROP_CURRENT_NOW, bsr_pkg::PROP_CURRENT_AVG,
                            bsr_pkg::PROP_CHARGE_FULL, bsr_pkg::PROP_CYCLE_COUNT:
                                prop_value[it.prop_code] = it.data;
                            default: ;
                        endcase
                        irq_status = irq_status | bsr_pkg::CHANGED_BATT;
                    end
                end
            end
            default: begin
                r.read_data = prop_value[it.prop_code];
            end
        endcase
        r.irq = (({30'd0, irq_status} & irq_enable) != '0);
        return r;
    endfunction

    function automatic void note_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] mismatch %s: expected 0x%08h, got 0x%08h", $realtime, what, exp_v,
                     got_v);
    endfunction

    // Driver: feeds transfers from stim_q, predicts each one as it is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!(s_axis_tvalid && !s_axis_tready)) begin
            if (s_axis_tvalid) begin
                pending_resp.push_back(apply_access(cur_access));
                if (stim_q.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 9);
            end
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (stim_q.size() > 0) begin
                cur_access = stim_q.pop_front();
                s_axis_tdata <= {7'd0, cur_access.prop_code, cur_access.ac_side,
                                 cur_access.data, cur_access.offset};
                s_axis_tuser <= cur_access.kind;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: result side backpressure and comparison
    always @(posedge i_clk) begin : monitor
        t_resp exp_r;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_resp.size() == 0) begin
                    note_mismatch("unexpected result read_data", '0, m_axis_tdata[31:0]);
                end else begin
                    exp_r = pending_resp.pop_front();
                    if (m_axis_tdata[31:0] !== exp_r.read_data)
                        note_mismatch("read_data", exp_r.read_data, m_axis_tdata[31:0]);
                    if (m_axis_tdata[32] !== exp_r.irq)
                        note_mismatch("irq", {31'd0, exp_r.irq}, {31'd0, m_axis_tdata[32]});
                end
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_axis_tready <= 1'b0;
            end else if (stim_q.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
                sink_stall = $urandom_range(1, 9) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("battery_status_register_block_unit regression: fail");
                $finish;
            end
        end
    end

    initial begin
        bsr_pkg::t_kind k;
        logic [11:0]    off;
        logic [31:0]    d;
        logic [11:0]    known_off [16];
        int             sel;
        t_resp          left_r;

        known_off = '{bsr_pkg::OFF_STATUS, bsr_pkg::OFF_ENABLE, bsr_pkg::OFF_ONLINE,
                      bsr_pkg::OFF_CHG_STATUS, bsr_pkg::OFF_HEALTH, bsr_pkg::OFF_PRESENT,
                      bsr_pkg::OFF_CAPACITY, bsr_pkg::OFF_VOLTAGE, bsr_pkg::OFF_TEMP,
                      bsr_pkg::OFF_CHARGE_CNT, bsr_pkg::OFF_VOLTAGE_MAX,
                      bsr_pkg::OFF_CURRENT_MAX, bsr_pkg::OFF_CURRENT_NOW,
                      bsr_pkg::OFF_CURRENT_AVG, bsr_pkg::OFF_CHARGE_FULL,
                      bsr_pkg::OFF_CYCLE_COUNT};

        // power-on contents
        prop_value[bsr_pkg::PROP_ONLINE]      = 32'd1;
        prop_value[bsr_pkg::PROP_STATUS]      = BATTERY_FITTED ? 32'd1 : 32'd0;
        prop_value[bsr_pkg::PROP_HEALTH]      = BATTERY_FITTED ? 32'd1 : 32'd0;
        prop_value[bsr_pkg::PROP_HAS_BATTERY] = BATTERY_FITTED ? 32'd1 : 32'd0;
        prop_value[bsr_pkg::PROP_PRESENT]     = BATTERY_FITTED ? 32'd1 : 32'd0;
        prop_value[bsr_pkg::PROP_CAPACITY]    = BATTERY_FITTED ? bsr_pkg::CAPACITY_RST_VAL
                                                               : 32'd0;
        prop_value[bsr_pkg::PROP_VOLTAGE]     = bsr_pkg::VOLTAGE_UV_VAL;
        prop_value[bsr_pkg::PROP_TEMP]        = bsr_pkg::TEMP_DECI_C_VAL;
        prop_value[bsr_pkg::PROP_CHARGE_CNT]  = BATTERY_FITTED ? bsr_pkg::CHARGE_CNT_VAL
                                                               : 32'd0;
        prop_value[bsr_pkg::PROP_VOLTAGE_MAX] = bsr_pkg::VOLTAGE_LIMIT_VAL;
        prop_value[bsr_pkg::PROP_CURRENT_MAX] = bsr_pkg::CURRENT_LIMIT_VAL;
        prop_value[bsr_pkg::PROP_CURRENT_NOW] = bsr_pkg::CURRENT_RST_VAL;
        prop_value[bsr_pkg::PROP_CURRENT_AVG] = bsr_pkg::CURRENT_RST_VAL;
        prop_value[bsr_pkg::PROP_CHARGE_FULL] = bsr_pkg::FULL_CHARGE_RST;
        prop_value[bsr_pkg::PROP_CYCLE_COUNT] = bsr_pkg::CYCLES_RST_VAL;
        prop_value[bsr_pkg::PROP_NONE]        = 32'd0;
        irq_status = '0;
        irq_enable = '0;

        // directed: status clear rules, side permissions, unknown offsets, ignored writes
        stim_q.push_back(mk_access(bsr_pkg::KIND_BUS_RD, bsr_pkg::OFF_STATUS, '0, 1'b0,
                                   bsr_pkg::PROP_ONLINE));
        stim_q.push_back(mk_access(bsr_pkg::KIND_HOST_SET, bsr_pkg::OFF_STATUS, '0, 1'b1,
                                   bsr_pkg::PROP_ONLINE));
        stim_q.push_back(mk_access(bsr_pkg::KIND_BUS_RD, bsr_pkg::OFF_STATUS, '0, 1'b0,
                                   bsr_pkg::PROP_ONLINE));
        stim_q.push_back(mk_access(bsr_pkg::KIND_BUS_WR, bsr_pkg::OFF_ENABLE, '1, 1'b0,
                                   bsr_pkg::PROP_ONLINE));
        stim_q.push_back(mk_access(bsr_pkg::KIND_BUS_RD, bsr_pkg::OFF_ENABLE, '0, 1'b0,
                                   bsr_pkg::PROP_ONLINE));
        stim_q.push_back(mk_access(bsr_pkg::KIND_BUS_RD, bsr_pkg::OFF_STATUS, '0, 1'b0,
                                   bsr_pkg::PROP_ONLINE));
        stim_q.push_back(mk_access(bsr_pkg::KIND_HOST_SET, 12'hFFF, '1, 1'b0,
                                   bsr_pkg::PROP_CAPACITY));
        stim_q.push_back(mk_access(bsr_pkg::KIND_HOST_SET, '0, 32'h1234_5678, 1'b0,
                                   bsr_pkg::PROP_VOLTAGE));
        stim_q.push_back(mk_access(bsr_pkg::KIND_HOST_SET, '0, '0, 1'b1,
                                   bsr_pkg::PROP_STATUS));
        stim_q.push_back(mk_access(bsr_pkg::KIND_BUS_RD, bsr_pkg::OFF_CAPACITY, '0, 1'b0,
                                   bsr_pkg::PROP_NONE));
        stim_q.push_back(mk_access(bsr_pkg::KIND_BUS_RD, bsr_pkg::OFF_VOLTAGE, '0, 1'b0,
                                   bsr_pkg::PROP_NONE));
        stim_q.push_back(mk_access(bsr_pkg::KIND_BUS_WR, bsr_pkg::OFF_ONLINE, '1, 1'b1,
                                   bsr_pkg::PROP_NONE));
        stim_q.push_back(mk_access(bsr_pkg::KIND_BUS_RD, bsr_pkg::OFF_ONLINE, '0, 1'b0,
                                   bsr_pkg::PROP_NONE));
        stim_q.push_back(mk_access(bsr_pkg::KIND_BUS_RD, 12'hFFF, '1, 1'b1,
                                   bsr_pkg::PROP_NONE));
        stim_q.push_back(mk_access(bsr_pkg::KIND_BUS_RD, 12'h03C, '0, 1'b0,
                                   bsr_pkg::PROP_NONE));
        stim_q.push_back(mk_access(bsr_pkg::KIND_BUS_RD, 12'h001, '0, 1'b0,
                                   bsr_pkg::PROP_NONE));
        stim_q.push_back(mk_access(bsr_pkg::KIND_BUS_WR, 12'hFFF, '0, 1'b0,
                                   bsr_pkg::PROP_NONE));
        stim_q.push_back(mk_access(bsr_pkg::KIND_HOST_RD, '0, '0, 1'b0,
                                   bsr_pkg::PROP_HAS_BATTERY));
        stim_q.push_back(mk_access(bsr_pkg::KIND_HOST_RD, '0, '0, 1'b0,
                                   bsr_pkg::PROP_NONE));
        stim_q.push_back(mk_access(bsr_pkg::KIND_HOST_RD, '0, '0, 1'b0,
                                   bsr_pkg::PROP_ONLINE));
        stim_q.push_back(mk_access(bsr_pkg::KIND_BUS_WR, bsr_pkg::OFF_ENABLE,
                                   {30'd0, bsr_pkg::CHANGED_BATT}, 1'b0, bsr_pkg::PROP_NONE));
        stim_q.push_back(mk_access(bsr_pkg::KIND_BUS_RD, bsr_pkg::OFF_STATUS, '0, 1'b0,
                                   bsr_pkg::PROP_NONE));
        stim_q.push_back(mk_access(bsr_pkg::KIND_BUS_RD, bsr_pkg::OFF_STATUS, '0, 1'b0,
                                   bsr_pkg::PROP_NONE));
        stim_q.push_back(mk_access(bsr_pkg::KIND_BUS_WR, bsr_pkg::OFF_ENABLE, '0, 1'b0,
                                   bsr_pkg::PROP_NONE));

        // random: mostly mapped offsets, interrupt enable kept busy with small masks
        repeat (RANDOM_ACCESSES) begin
            sel = $urandom_range(0, 99);
            if (sel < 35)      k = bsr_pkg::KIND_BUS_RD;
            else if (sel < 50) k = bsr_pkg::KIND_BUS_WR;
            else if (sel < 75) k = bsr_pkg::KIND_HOST_SET;
            else               k = bsr_pkg::KIND_HOST_RD;
            sel = $urandom_range(0, 99);
            if (sel < 20)      off = bsr_pkg::OFF_STATUS;
            else if (sel < 75) off = known_off[4'($urandom_range(0, 15))];
            else               off = 12'($urandom_range(0, 4095));
            if (k == bsr_pkg::KIND_BUS_WR && $urandom_range(0, 3) != 0)
                off = bsr_pkg::OFF_ENABLE;
            sel = $urandom_range(0, 9);
            if (sel == 0)      d = '0;
            else if (sel == 1) d = '1;
            else if (sel < 5)  d = $urandom_range(0, 3);
            else               d = $urandom;
            stim_q.push_back(mk_access(k, off, d, 1'($urandom_range(0, 1)),
                                       4'($urandom_range(0, 15))));
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() > 0 || s_axis_tvalid || pending_resp.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        while (pending_resp.size() > 0) begin
            left_r = pending_resp.pop_front();
            note_mismatch("missing result read_data", left_r.read_data, '0);
        end

        if (mismatch_count == 0)
            $display("battery_status_register_block_unit regression: pass");
        else
            $display("battery_status_register_block_unit regression: fail");
        $finish;
    end

endmodule
